// ===== src/cem_pkg.sv =====
// cem_pkg: shared types and constants for the capacitor energy model.
// No dependencies; imported by capacitor_energy_model and by the bench tb.
`default_nettype none

package cem_pkg;

   localparam int unsigned CSR_AW = 5;

   localparam logic [2:0] CSR_CAPACITANCE = 3'd0;
   localparam logic [2:0] CSR_START       = 3'd1;
   localparam logic [2:0] CSR_FLOOR       = 3'd2;
   localparam logic [2:0] CSR_TRICKLE     = 3'd3;
   localparam logic [2:0] CSR_SLEEP       = 3'd4;
   localparam logic [2:0] CSR_LOW         = 3'd5;

   localparam logic [15:0] CAP_RESET     = 16'd2000;
   localparam logic [14:0] START_RESET   = 15'd9000;
   localparam logic [14:0] FLOOR_RESET   = 15'd5400;
   localparam logic [19:0] TRICKLE_RESET = 20'd1200;
   localparam logic [14:0] SLEEP_RESET   = 15'd5500;
   localparam logic [14:0] LOW_RESET     = 15'd7000;

   localparam logic [1:0] LEVEL_CRITICAL = 2'd0;
   localparam logic [1:0] LEVEL_LOW      = 2'd1;
   localparam logic [1:0] LEVEL_OK       = 2'd2;

   localparam logic [1:0] SEL_START = 2'd0;
   localparam logic [1:0] SEL_FLOOR = 2'd1;
   localparam logic [1:0] SEL_SLEEP = 2'd2;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_EN_SQ    = 12'b0000_0000_0010,
      S_EN_MUL   = 12'b0000_0000_0100,
      S_EN_WR    = 12'b0000_0000_1000,
      S_NET_MUL  = 12'b0000_0001_0000,
      S_UPDATE   = 12'b0000_0010_0000,
      S_RT_SQ    = 12'b0000_0100_0000,
      S_RT_MUL   = 12'b0000_1000_0000,
      S_RT_CMP   = 12'b0001_0000_0000,
      S_DIV_INIT = 12'b0010_0000_0000,
      S_DIV_STEP = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } state_type;

endpackage

`default_nettype wire

// ===== src/capacitor_energy_model.sv =====
// Capacitor energy model top level: register file, sequencer and one shared
// 20x32 multiplier with a bit-serial divider. Depends on cem_pkg.
//
// Usage: each poll is one transfer on req_* (tick stamp and load power); one
// result per poll leaves on rsp_* (rail voltage, level band, warning time).
// Registers are to be written over the csr_* APB port only while no poll is
// in flight; the block itself does not enforce this. The 32-step divide runs
// only when the cell is draining, its energy is above the sleep level and
// the warning does not saturate. The rail square root finds 15 result bits,
// each from a square and a scale on the shared multiplier, then a compare.
// Only one poll is in flight: req_tready is high only while the sequencer is
// idle, so the next poll is taken only once the last is in the output register.
// The result sits in an output register; a stalled receiver holds it there
// while the next poll is taken and worked, and a finished poll waits in the
// last step until the register frees up.
// Reset (synchronous, active high) loads the register defaults, clears the
// stored energy and the primed flag; the first poll then starts from full
// with zero elapsed time.
`default_nettype none

module capacitor_energy_model
   import cem_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output      logic              req_tready,
   input  wire logic [55:0]       req_tdata,   // tick_stamp[31:0], load_uw[51:32]
   output      logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   output      logic [55:0]       rsp_tdata,   // rail_mv[14:0], energy_level[16:15],
                                               // sleep_us[48:17]
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output      logic [31:0]       csr_prdata,
   output      logic              csr_pready
);

   // configuration
   logic [15:0] cap_ff;
   logic [14:0] start_ff, floor_ff, sleep_ff, low_ff;
   logic [19:0] trickle_ff;

   // control
   state_type   state_ff, state_in;
   logic        primed_ff, primed_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [47:0] energy_ff, energy_in;
   logic [31:0] last_stamp_ff, last_stamp_in;
   logic        first_ff, first_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [19:0] load_ff, load_in;
   logic [47:0] full_ff, full_in, floor_e_ff, floor_e_in, sleep_e_ff, sleep_e_in;
   logic [1:0]  sel_ff, sel_in;
   logic [51:0] prod_ff, prod_in;
   logic [14:0] root_ff, root_in;
   logic [3:0]  bit_ff, bit_in;
   logic [22:0] div_ff, div_in, rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] warn_ff, warn_in;
   logic [14:0] rsp_rail_ff, rsp_rail_in;
   logic [1:0]  rsp_level_ff, rsp_level_in;
   logic [31:0] rsp_warn_ff, rsp_warn_in;

   logic        csr_wr;
   logic        req_xfer;
   logic [15:0] cap_eff;
   logic [17:0] c3;
   logic        drain;
   logic [19:0] net_mag;
   logic [14:0] mv_sel;
   logic [19:0] mul_a;
   logic [31:0] mul_b;
   logic [14:0] cand;
   logic [15:0] t_odd;
   logic [47:0] base;
   logic [53:0] e_sum, e_clamp;
   logic [47:0] spare;
   logic [22:0] div_val;
   logic [23:0] trial;
   logic        trial_ok;
   logic [1:0]  level;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_warn_ff, rsp_level_ff, rsp_rail_ff};

   always_comb begin
      unique case (csr_paddr[4:2])
         CSR_CAPACITANCE: csr_prdata = {16'd0, cap_ff};
         CSR_START:       csr_prdata = {17'd0, start_ff};
         CSR_FLOOR:       csr_prdata = {17'd0, floor_ff};
         CSR_TRICKLE:     csr_prdata = {12'd0, trickle_ff};
         CSR_SLEEP:       csr_prdata = {17'd0, sleep_ff};
         CSR_LOW:         csr_prdata = {17'd0, low_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= CAP_RESET;
         start_ff   <= START_RESET;
         floor_ff   <= FLOOR_RESET;
         trickle_ff <= TRICKLE_RESET;
         sleep_ff   <= SLEEP_RESET;
         low_ff     <= LOW_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            CSR_CAPACITANCE: cap_ff     <= csr_pwdata[15:0];
            CSR_START:       start_ff   <= csr_pwdata[14:0];
            CSR_FLOOR:       floor_ff   <= csr_pwdata[14:0];
            CSR_TRICKLE:     trickle_ff <= csr_pwdata[19:0];
            CSR_SLEEP:       sleep_ff   <= csr_pwdata[14:0];
            CSR_LOW:         low_ff     <= csr_pwdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // shared arithmetic
   assign cap_eff = (cap_ff == 16'd0) ? 16'd1 : cap_ff;
   assign c3      = {1'b0, cap_eff, 1'b0} + {2'b00, cap_eff};
   assign drain   = (load_ff > trickle_ff);
   assign net_mag = drain ? (load_ff - trickle_ff) : (trickle_ff - load_ff);
   assign cand    = root_ff | (15'd1 << bit_ff);
   assign t_odd   = {cand, 1'b0} - 16'd1;

   always_comb begin
      unique case (sel_ff)
         SEL_START: mv_sel = start_ff;
         SEL_FLOOR: mv_sel = floor_ff;
         SEL_SLEEP: mv_sel = sleep_ff;
         default:   mv_sel = 15'd0;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_EN_SQ: begin
            mul_a = {5'd0, mv_sel};
            mul_b = {17'd0, mv_sel};
         end
         S_EN_MUL: begin
            mul_a = {2'b00, c3};
            mul_b = {2'b00, prod_ff[29:0]};
         end
         S_NET_MUL: begin
            mul_a = net_mag;
            mul_b = elapsed_ff;
         end
         S_RT_SQ: begin
            mul_a = {4'd0, t_odd};
            mul_b = {16'd0, t_odd};
         end
         S_RT_MUL: begin
            mul_a = {2'b00, c3};
            mul_b = prod_ff[31:0];
         end
         default: begin
            mul_a = 20'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign prod_in = {32'd0, mul_a} * {20'd0, mul_b};

   // energy update, 54-bit signed
   assign base    = first_ff ? full_ff : energy_ff;
   assign e_sum   = drain ? ({6'd0, base} - {2'b00, prod_ff})
                          : ({6'd0, base} + {2'b00, prod_ff});
   assign e_clamp = ($signed(e_sum) > $signed({6'd0, full_ff})) ? {6'd0, full_ff} : e_sum;

   assign spare    = energy_ff - sleep_e_ff;
   assign div_val  = {1'b0, net_mag, 2'b00} + {2'b00, net_mag, 1'b0};
   assign trial    = {rem_ff, quo_ff[31]};
   assign trial_ok = (trial >= {1'b0, div_ff});

   always_comb begin
      if (root_ff < sleep_ff) begin
         level = LEVEL_CRITICAL;
      end else if (root_ff < low_ff) begin
         level = LEVEL_LOW;
      end else begin
         level = LEVEL_OK;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      primed_in     = primed_ff;
      energy_in     = energy_ff;
      last_stamp_in = last_stamp_ff;
      first_in      = first_ff;
      elapsed_in    = elapsed_ff;
      load_in       = load_ff;
      full_in       = full_ff;
      floor_e_in    = floor_e_ff;
      sleep_e_in    = sleep_e_ff;
      sel_in        = sel_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      warn_in       = warn_ff;
      rsp_rail_in   = rsp_rail_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_warn_in   = rsp_warn_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               elapsed_in    = primed_ff ? (req_tdata[31:0] - last_stamp_ff) : 32'd0;
               last_stamp_in = req_tdata[31:0];
               load_in       = req_tdata[51:32];
               first_in      = ~primed_ff;
               primed_in     = 1'b1;
               sel_in        = SEL_START;
               state_in      = S_EN_SQ;
            end
         end
         S_EN_SQ:  state_in = S_EN_MUL;
         S_EN_MUL: state_in = S_EN_WR;
         S_EN_WR: begin
            unique case (sel_ff)
               SEL_START: full_in    = prod_ff[47:0];
               SEL_FLOOR: floor_e_in = prod_ff[47:0];
               default:   sleep_e_in = prod_ff[47:0];
            endcase
            if (sel_ff == SEL_SLEEP) begin
               state_in = S_NET_MUL;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_EN_SQ;
            end
         end
         S_NET_MUL: state_in = S_UPDATE;
         S_UPDATE: begin
            if ($signed(e_clamp) <= $signed({6'd0, floor_e_ff})) begin
               energy_in = full_ff;
            end else begin
               energy_in = e_clamp[47:0];
            end
            root_in  = 15'd0;
            bit_in   = 4'd14;
            state_in = S_RT_SQ;
         end
         S_RT_SQ:  state_in = S_RT_MUL;
         S_RT_MUL: state_in = S_RT_CMP;
         S_RT_CMP: begin
            if ({energy_ff, 2'b00} >= prod_ff[49:0]) begin
               root_in = cand;
            end
            if (bit_ff == 4'd0) begin
               state_in = S_DIV_INIT;
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = S_RT_SQ;
            end
         end
         S_DIV_INIT: begin
            div_in = div_val;
            if (!(energy_ff > sleep_e_ff) || !drain) begin
               warn_in  = 32'd0;
               state_in = S_DONE;
            end else if ({7'd0, spare[47:32]} >= div_val) begin
               warn_in  = 32'hFFFF_FFFF;
               state_in = S_DONE;
            end else begin
               rem_in   = {7'd0, spare[47:32]};
               quo_in   = spare[31:0];
               cnt_in   = 5'd31;
               state_in = S_DIV_STEP;
            end
         end
         S_DIV_STEP: begin
            if (trial_ok) begin
               rem_in = trial[22:0] - div_ff;
            end else begin
               rem_in = trial[22:0];
            end
            quo_in = {quo_ff[30:0], trial_ok};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               warn_in  = {quo_ff[30:0], trial_ok};
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_rail_in  = root_ff;
               rsp_level_in = level;
               rsp_warn_in  = warn_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         primed_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         energy_ff     <= 48'd0;
         last_stamp_ff <= 32'd0;
      end else begin
         state_ff      <= state_in;
         primed_ff     <= primed_in;
         rsp_valid_ff  <= rsp_valid_in;
         energy_ff     <= energy_in;
         last_stamp_ff <= last_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      elapsed_ff   <= elapsed_in;
      load_ff      <= load_in;
      full_ff      <= full_in;
      floor_e_ff   <= floor_e_in;
      sleep_e_ff   <= sleep_e_in;
      sel_ff       <= sel_in;
      prod_ff      <= prod_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      warn_ff      <= warn_in;
      rsp_rail_ff  <= rsp_rail_in;
      rsp_level_ff <= rsp_level_in;
      rsp_warn_ff  <= rsp_warn_in;
   end

endmodule

`default_nettype wire

// ===== src/cem_checker.sv =====
// cem_checker: port-level assertions for capacitor_energy_model, bound to it.
// Depends only on the top level's ports.
`default_nettype none

module cem_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp changed while stalled");

   // one poll in flight
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted during work");

   a_level_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:15] != 2'd3)
      else $error("bad level band");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset left transfer pending");

endmodule

bind capacitor_energy_model cem_checker u_cem_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for capacitor_energy_model; polls go in on req_*, reports are
// checked on rsp_*, registers are set over csr_*. Depends on cem_pkg and the block's RTL.
// Expected reports come from an exact integer energy tracker kept in the bench.

module tb
   import cem_pkg::*;
();

   localparam int STALL_LIMIT = 3000;

   typedef struct packed {
      logic [31:0] sleep_us;
      logic [1:0]  level;
      logic [14:0] rail_mv;
   } rail_report_type;

   class cap_tracker_type;
      bit [15:0] cap_uf = CAP_RESET;
      bit [14:0] start_mv = START_RESET;
      bit [14:0] floor_mv = FLOOR_RESET;
      bit [19:0] trickle_uw = TRICKLE_RESET;
      bit [14:0] sleep_mv = SLEEP_RESET;
      bit [14:0] low_mv = LOW_RESET;
      bit [47:0] energy;
      bit [31:0] last_stamp;
      bit        primed;
      rail_report_type expected_reports[$];
      int        mismatches;

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            CSR_CAPACITANCE: cap_uf = value[15:0];
            CSR_START: start_mv = value[14:0];
            CSR_FLOOR: floor_mv = value[14:0];
            CSR_TRICKLE: trickle_uw = value[19:0];
            CSR_SLEEP: sleep_mv = value[14:0];
            CSR_LOW: low_mv = value[14:0];
            default: ;
         endcase
      endfunction

      function longint unsigned charge_of(bit [14:0] mv);
         longint unsigned c, v;
         c = (cap_uf == 0) ? 1 : cap_uf;
         v = mv;
         return 3 * c * v * v;
      endfunction

      // largest m with 4E >= 3C(2m-1)^2: nearest mV, ties up
      function bit [14:0] rail_of(longint unsigned e);
         longint unsigned c3, t;
         int unsigned lo, hi, mid;
         c3 = (cap_uf == 0) ? 1 : cap_uf;
         c3 = 3 * c3;
         lo = 0;
         hi = 32767;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = mid;
            t = 2 * t - 1;
            if (4 * e >= c3 * t * t) lo = mid;
            else hi = mid - 1;
         end
         return lo[14:0];
      endfunction

      function rail_report_type predict_report(bit [31:0] stamp, bit [19:0] load);
         rail_report_type r;
         longint full_e, floor_e, sum, en, tr, ld, el, net;
         longint unsigned sleep_e, spare, q;
         bit [31:0] elapsed;
         full_e = charge_of(start_mv);
         floor_e = charge_of(floor_mv);
         if (!primed) begin
            energy = full_e[47:0];
            last_stamp = stamp;
            primed = 1'b1;
         end
         elapsed = stamp - last_stamp;
         last_stamp = stamp;
         en = energy;
         tr = trickle_uw;
         ld = load;
         el = elapsed;
         sum = en + (tr - ld) * el;
         if (sum > full_e) sum = full_e;
         if (sum <= floor_e) sum = full_e;
         energy = sum[47:0];
         r.rail_mv = rail_of(energy);
         if (r.rail_mv < sleep_mv) r.level = LEVEL_CRITICAL;
         else if (r.rail_mv < low_mv) r.level = LEVEL_LOW;
         else r.level = LEVEL_OK;
         sleep_e = charge_of(sleep_mv);
         net = ld - tr;
         r.sleep_us = '0;
         if (energy > sleep_e && net > 0) begin
            spare = energy - sleep_e;
            q = spare / (6 * net);
            r.sleep_us = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
         end
         return r;
      endfunction

      function void take_poll(bit [31:0] stamp, bit [19:0] load);
         expected_reports.push_back(predict_report(stamp, load));
      endfunction

      function void check_report(logic [55:0] word);
         rail_report_type want;
         if (expected_reports.size() == 0) begin
            $error("report with no poll outstanding: %h", word);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (word[14:0] !== want.rail_mv) begin
               $error("rail_mv expected %0d actual %0d", want.rail_mv, word[14:0]);
               mismatches++;
            end
            if (word[16:15] !== want.level) begin
               $error("energy_level expected %0d actual %0d", want.level, word[16:15]);
               mismatches++;
            end
            if (word[48:17] !== want.sleep_us) begin
               $error("sleep_us expected %0d actual %0d", want.sleep_us, word[48:17]);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [55:0]       req_tdata = '0;   // tick_stamp[31:0], load_uw[51:32]
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [55:0]       rsp_tdata;        // rail_mv[14:0], energy_level[16:15], sleep_us[48:17]
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   cap_tracker_type tracker = new();
   bit [31:0]  tick_now;
   int         polls_sent;
   int         quiet_cycles;

   capacitor_energy_model uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_report(rsp_tdata);
         if (req_tvalid && req_tready) tracker.take_poll(req_tdata[31:0], req_tdata[51:32]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_poll(input bit [31:0] stamp, input bit [19:0] load);
      int gap;
      gap = ((polls_sent % 200) >= 160) ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {4'b0, load, stamp};
      req_tvalid <= 1'b1;
      tick_now = stamp;
      polls_sent++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random_poll();
      longint unsigned span;
      bit [31:0] delta;
      bit [19:0] load;
      int pick, t;
      // ticks to drain a full cell at about 1 W
      span = (tracker.charge_of(tracker.start_mv) >> 20) + 1;
      pick = $urandom_range(0, 99);
      if (pick < 60) delta = $urandom_range(0, span[31:0] / 3);
      else if (pick < 75) delta = $urandom_range(0, 255);
      else if (pick < 90) delta = $urandom();
      else delta = 0;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         load = 20'($urandom());
      end else if (pick < 70) begin
         t = $urandom_range(0, 32);
         t = t + tracker.trickle_uw - 16;
         if (t < 0) t = 0;
         if (t > 20'hFFFFF) t = 20'hFFFFF;
         load = 20'(t);
      end else if (pick < 85) begin
         load = $urandom_range(0, 1) ? 20'hFFFFF : 20'h0;
      end else begin
         load = 20'($urandom_range(0, 2 * tracker.trickle_uw + 1));
      end
      send_poll(tick_now + delta, load);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(idx, value);
   endtask

   task automatic configure(input int cap, input int start, input int flr,
                            input int trickle, input int sleep, input int low);
      drain();
      write_register(CSR_CAPACITANCE, cap);
      write_register(CSR_START, start);
      write_register(CSR_FLOOR, flr);
      write_register(CSR_TRICKLE, trickle);
      write_register(CSR_SLEEP, sleep);
      write_register(CSR_LOW, low);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_polls(input int count);
      repeat (count) send_random_poll();
   endtask

   initial begin
      int rnd_start, rnd_sleep;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first poll primes to full, then wrap, drain into low and critical bands
      send_poll(32'hFFFF_FF00, 20'd0);
      send_poll(32'hFFFF_FF00, 20'hFFFFF);
      send_poll(32'h0000_0100, 20'hFFFFF);
      send_poll(tick_now + 32'd200000, 20'hFFFFF);
      send_poll(tick_now + 32'd50000, 20'hFFFFF);
      send_poll(tick_now + 32'd41000, 20'hFFFFF);
      send_poll(tick_now + 32'd1000, 20'hFFFFF);
      send_poll(tick_now + 32'd1000, 20'd1201);
      send_poll(tick_now + 32'd5000, 20'd1200);
      send_poll(tick_now + 32'd5000, 20'd0);
      send_poll(tick_now + 32'hFFFF_FFFF, 20'd0);
      send_poll(tick_now + 32'hFFFF_FFFF, 20'hFFFFF);
      send_poll(32'h0000_0000, 20'hFFFFF);
      send_poll(32'hFFFF_FFFF, 20'd0);

      configure(2000, 9000, 5400, 1200, 5500, 7000);
      run_polls(262);
      configure(65535, 20000, 0, 1048575, 20000, 20000);
      run_polls(262);
      configure(1, 1000, 0, 0, 0, 0);
      run_polls(262);
      configure(0, 5000, 20000, 500, 3000, 4000);
      run_polls(262);
      configure(100, 12000, 3000, 50000, 6000, 9000);
      run_polls(262);
      repeat (2) begin
         rnd_start = $urandom_range(1000, 20000);
         rnd_sleep = $urandom_range(0, rnd_start);
         configure($urandom_range(1, 65535), rnd_start, $urandom_range(0, rnd_start - 1),
                   $urandom_range(0, 1048575), rnd_sleep, $urandom_range(rnd_sleep, rnd_start));
         run_polls(262);
      end

      drain();
      repeat (120) @(posedge clock);
      if (tracker.mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      int stall;
      int taken;
      taken = 0;
      forever begin
         if (taken == 900) begin
            // long hold-off so the block fills and stalls its input
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end else begin
            stall = ((taken % 150) >= 120) ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               if ($urandom_range(0, 1)) do @(posedge clock); while (!rsp_tvalid);
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

endmodule
